// ===== hdl/raycast_column_ray_direction_defines.svh =====
// Assertion macros for the file that carries the concurrent checks.
`ifndef RAYCAST_COLUMN_RAY_DIRECTION_DEFINES_SVH
`define RAYCAST_COLUMN_RAY_DIRECTION_DEFINES_SVH

// Check that is switched off while reset is asserted.
`define RCRD_ASSERT(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// Check that also holds through reset.
`define RCRD_ASSERT_NR(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== hdl/rcrd_pkg.sv =====
package rcrd_pkg;

    // Default number of fraction bits of the Q1.x data.
    localparam int FRAC_BITS_DEF = 14;

    // Width of every data port and configuration register.
    localparam int DW = 16;

    // Ray components are normalized to magnitudes below 2^30 before squaring.
    localparam int AW = 30;
    // Sum of two squares of AW-bit values.
    localparam int SQW = 2 * AW + 1;
    // Integer square root of an SQW-bit value.
    localparam int LW = (SQW + 1) / 2;

    // Configuration register indexes.
    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] REG_FORWARD_X  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_FORWARD_Y  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_HALF_WIDTH = 2'd2;

    // Reset value of forward_y: one in Q1.14.
    localparam logic signed [DW-1:0] FORWARD_Y_RST = 16'sd16384;

    typedef struct packed {
        logic neg_x;
        logic neg_y;
        logic zero_len;
    } flags_t;

    typedef struct packed {
        logic [AW-1:0] ax;
        logic [AW-1:0] ay;
        flags_t        flg;
    } side_t;

    typedef struct packed {
        logic signed [DW-1:0] ray_x;
        logic signed [DW-1:0] ray_y;
        logic                 zero_len;
    } res_t;

endpackage

// ===== hdl/raycast_column_ray_direction.sv =====
// Channel   Direction  Handshake          Payload
// s_        in         s_valid / s_ready  s_screen_coord (signed Q1.14)
// m_        out        m_valid / m_ready  m_ray_x, m_ray_y (signed Q1.14), m_zero_length
// cfg_      in         cfg_wr_en          cfg_index, cfg_wdata (write only)
//
// One item is accepted per clock while the output buffer has room; each item gives
// exactly one result item. Nine stages form and normalize the ray, 31 stages extract
// the square root one bit each, FRAC_BITS + 3 stages divide and round, and the result
// then passes through the two-entry output buffer.
// Reset is synchronous and active low; s_ready stays low in the first cycle after it.
// A stalled output fills the output buffer, then the whole pipeline holds in place.
module raycast_column_ray_direction #(
    parameter int FRAC_BITS = rcrd_pkg::FRAC_BITS_DEF
) (
    input  logic                                    aclk,
    input  logic                                    aresetn,
    input  logic                                    cfg_wr_en,
    input  logic        [rcrd_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic        [rcrd_pkg::DW-1:0]          cfg_wdata,
    input  logic                                    s_valid,
    output logic                                    s_ready,
    input  logic signed [rcrd_pkg::DW-1:0]          s_screen_coord,
    output logic                                    m_valid,
    input  logic                                    m_ready,
    output logic signed [rcrd_pkg::DW-1:0]          m_ray_x,
    output logic signed [rcrd_pkg::DW-1:0]          m_ray_y,
    output logic                                    m_zero_length
);

    // Camera registers. The user must change them only while the block is idle, since
    // the block does not enforce it and every pipeline stage reads them directly.
    logic signed [rcrd_pkg::DW-1:0] fwd_x_reg;
    logic signed [rcrd_pkg::DW-1:0] fwd_y_reg;
    logic        [rcrd_pkg::DW-1:0] half_width_reg;
    logic                           run_reg;

    logic                     pipe_en;
    logic                     buf_space;
    logic                     front_valid;
    rcrd_pkg::side_t          front_side;
    logic [rcrd_pkg::SQW-1:0] front_sum;
    logic                     sqrt_valid;
    rcrd_pkg::side_t          sqrt_side;
    logic [rcrd_pkg::LW-1:0]  sqrt_root;
    logic                     div_valid;
    rcrd_pkg::res_t           div_res;
    rcrd_pkg::res_t           m_res;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fwd_x_reg      <= '0;
            fwd_y_reg      <= rcrd_pkg::FORWARD_Y_RST;
            half_width_reg <= '0;
            run_reg        <= 1'b0;
        end else begin
            run_reg <= 1'b1;
            if (cfg_wr_en) begin
                unique case (cfg_index)
                    rcrd_pkg::REG_FORWARD_X:  fwd_x_reg      <= cfg_wdata;
                    rcrd_pkg::REG_FORWARD_Y:  fwd_y_reg      <= cfg_wdata;
                    rcrd_pkg::REG_HALF_WIDTH: half_width_reg <= cfg_wdata;
                    default: ;
                endcase
            end
        end
    end

    // The whole pipeline advances together. The enable comes from registered
    // buffer occupancy, so s_ready does not depend on m_ready in the same cycle,
    // and a result in the buffer never blocks the next item while there is room.
    assign pipe_en = run_reg && buf_space;
    assign s_ready = pipe_en;

    // Ray formation, magnitude, normalizing shift and sum of squares.
    rcrd_front #(
        .FRAC_BITS (FRAC_BITS)
    ) u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .en         (pipe_en),
        .in_valid   (s_valid),
        .in_coord   (s_screen_coord),
        .fwd_x      (fwd_x_reg),
        .fwd_y      (fwd_y_reg),
        .half_width (half_width_reg),
        .out_valid  (front_valid),
        .out_side   (front_side),
        .out_sum    (front_sum)
    );

    // Ray length as the floor of the square root.
    rcrd_isqrt u_isqrt (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (pipe_en),
        .in_valid  (front_valid),
        .in_side   (front_side),
        .in_sum    (front_sum),
        .out_valid (sqrt_valid),
        .out_side  (sqrt_side),
        .out_root  (sqrt_root)
    );

    // Both components divided by the length, rounded, saturated and signed.
    rcrd_div #(
        .FRAC_BITS (FRAC_BITS)
    ) u_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (pipe_en),
        .in_valid  (sqrt_valid),
        .in_side   (sqrt_side),
        .in_root   (sqrt_root),
        .out_valid (div_valid),
        .out_res   (div_res)
    );

    rcrd_out_buf u_out_buf (
        .aclk    (aclk),
        .aresetn (aresetn),
        .push    (div_valid && pipe_en),
        .in_res  (div_res),
        .space   (buf_space),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_res   (m_res)
    );

    assign m_ray_x       = m_res.ray_x;
    assign m_ray_y       = m_res.ray_y;
    assign m_zero_length = m_res.zero_len;

endmodule

// ===== hdl/rcrd_front.sv =====
module rcrd_front #(
    parameter int FRAC_BITS = rcrd_pkg::FRAC_BITS_DEF
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             en,
    input  logic                             in_valid,
    input  logic signed [rcrd_pkg::DW-1:0]   in_coord,
    input  logic signed [rcrd_pkg::DW-1:0]   fwd_x,
    input  logic signed [rcrd_pkg::DW-1:0]   fwd_y,
    input  logic        [rcrd_pkg::DW-1:0]   half_width,
    output logic                             out_valid,
    output rcrd_pkg::side_t                  out_side,
    output logic        [rcrd_pkg::SQW-1:0]  out_sum
);

    localparam int US   = FRAC_BITS + 12;
    localparam int HW   = 32;
    localparam int PW   = 48;
    localparam int RW   = (((US + 16) > PW) ? (US + 16) : PW) + 1;
    localparam int NG   = (RW + 7) / 8;
    localparam int GW   = NG * 8;
    localparam int BLW  = $clog2(GW + 1);
    localparam int SMAX = RW - 1 - rcrd_pkg::AW;
    localparam int SW   = $clog2(SMAX + 1);
    localparam int NSTG = 9;

    logic [NSTG-1:0] vld_reg;

    logic signed [HW:0]   hc_next;
    logic signed [HW-1:0] hc_reg;
    logic signed [PW-1:0] px_reg;
    logic signed [PW-1:0] py_reg;
    logic signed [RW-1:0] rx_next;
    logic signed [RW-1:0] ry_next;
    logic signed [RW-1:0] rx_reg;
    logic signed [RW-1:0] ry_reg;

    logic [RW-1:0]    mx4_next;
    logic [RW-1:0]    my4_next;
    logic [RW-1:0]    mx4_reg;
    logic [RW-1:0]    my4_reg;
    rcrd_pkg::flags_t flg4_next;
    rcrd_pkg::flags_t flg4_reg;

    logic [GW-1:0]    orv;
    logic [NG-1:0]    gnz_next;
    logic [NG-1:0]    gnz_reg;
    logic [3:0]       glen_next [NG];
    logic [3:0]       glen_reg  [NG];
    logic [RW-1:0]    mx5_reg;
    logic [RW-1:0]    my5_reg;
    rcrd_pkg::flags_t flg5_reg;

    logic [BLW-1:0]   blen;
    logic [SW-1:0]    sh_next;
    logic [SW-1:0]    sh_reg;
    logic [RW-1:0]    mx6_reg;
    logic [RW-1:0]    my6_reg;
    rcrd_pkg::flags_t flg6_reg;

    logic [RW-1:0]    shx;
    logic [RW-1:0]    shy;
    rcrd_pkg::side_t  side7_next;
    rcrd_pkg::side_t  side7_reg;

    logic [2*rcrd_pkg::AW-1:0] sqx_reg;
    logic [2*rcrd_pkg::AW-1:0] sqy_reg;
    rcrd_pkg::side_t           side8_reg;

    logic [rcrd_pkg::SQW-1:0]  sum_reg;
    rcrd_pkg::side_t           side9_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (en) begin
            vld_reg <= {vld_reg[NSTG-2:0], in_valid};
        end
    end

    assign hc_next = $signed({1'b0, half_width}) * in_coord;
    assign rx_next = (RW'(fwd_x) <<< US) + RW'(py_reg);
    assign ry_next = (RW'(fwd_y) <<< US) - RW'(px_reg);

    always_comb begin
        mx4_next           = rx_reg[RW-1] ? RW'(-rx_reg) : RW'(rx_reg);
        my4_next           = ry_reg[RW-1] ? RW'(-ry_reg) : RW'(ry_reg);
        flg4_next.neg_x    = rx_reg[RW-1];
        flg4_next.neg_y    = ry_reg[RW-1];
        flg4_next.zero_len = (rx_reg == '0) && (ry_reg == '0);
    end

    // Bit length of each byte of the OR of both magnitudes.
    assign orv = GW'(mx4_reg | my4_reg);

    always_comb begin
        for (int g = 0; g < NG; g++) begin
            gnz_next[g]  = |orv[g*8 +: 8];
            glen_next[g] = 4'd0;
            for (int b = 0; b < 8; b++) begin
                if (orv[g*8 + b]) begin
                    glen_next[g] = 4'(b + 1);
                end
            end
        end
    end

    always_comb begin
        blen = '0;
        for (int g = 0; g < NG; g++) begin
            if (gnz_reg[g]) begin
                blen = BLW'(g * 8) + BLW'(glen_reg[g]);
            end
        end
        sh_next = (blen > BLW'(rcrd_pkg::AW)) ? SW'(blen - BLW'(rcrd_pkg::AW)) : '0;
    end

    always_comb begin
        shx            = mx6_reg >> sh_reg;
        shy            = my6_reg >> sh_reg;
        side7_next.ax  = shx[rcrd_pkg::AW-1:0];
        side7_next.ay  = shy[rcrd_pkg::AW-1:0];
        side7_next.flg = flg6_reg;
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            hc_reg    <= hc_next[HW-1:0];
            px_reg    <= hc_reg * fwd_x;
            py_reg    <= hc_reg * fwd_y;
            rx_reg    <= rx_next;
            ry_reg    <= ry_next;
            mx4_reg   <= mx4_next;
            my4_reg   <= my4_next;
            flg4_reg  <= flg4_next;
            gnz_reg   <= gnz_next;
            glen_reg  <= glen_next;
            mx5_reg   <= mx4_reg;
            my5_reg   <= my4_reg;
            flg5_reg  <= flg4_reg;
            sh_reg    <= sh_next;
            mx6_reg   <= mx5_reg;
            my6_reg   <= my5_reg;
            flg6_reg  <= flg5_reg;
            side7_reg <= side7_next;
            sqx_reg   <= side7_reg.ax * side7_reg.ax;
            sqy_reg   <= side7_reg.ay * side7_reg.ay;
            side8_reg <= side7_reg;
            sum_reg   <= rcrd_pkg::SQW'(sqx_reg) + rcrd_pkg::SQW'(sqy_reg);
            side9_reg <= side8_reg;
        end
    end

    assign out_valid = vld_reg[NSTG-1];
    assign out_side  = side9_reg;
    assign out_sum   = sum_reg;

endmodule

// ===== hdl/rcrd_isqrt.sv =====
module rcrd_isqrt (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            en,
    input  logic                            in_valid,
    input  rcrd_pkg::side_t                 in_side,
    input  logic [rcrd_pkg::SQW-1:0]        in_sum,
    output logic                            out_valid,
    output rcrd_pkg::side_t                 out_side,
    output logic [rcrd_pkg::LW-1:0]         out_root
);

    localparam int LW  = rcrd_pkg::LW;
    localparam int NS  = LW;
    localparam int NW  = 2 * LW;
    localparam int RMW = LW + 2;

    logic [NS-1:0]   vld_reg;
    logic [NW-1:0]   n_reg    [NS];
    logic [LW-1:0]   r_reg    [NS];
    logic [RMW-1:0]  rem_reg  [NS];
    rcrd_pkg::side_t side_reg [NS];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (en) begin
            vld_reg <= {vld_reg[NS-2:0], in_valid};
        end
    end

    // One root bit per stage: two radicand bits enter the remainder each step.
    for (genvar i = 0; i < NS; i++) begin : g_step
        logic [NW-1:0]   n_in;
        logic [LW-1:0]   r_in;
        logic [RMW-1:0]  rem_in;
        logic [RMW-1:0]  rem_sh;
        logic [RMW-1:0]  trial;
        rcrd_pkg::side_t side_in;
        logic            ge;

        if (i == 0) begin : g_head
            assign n_in    = NW'(in_sum);
            assign r_in    = '0;
            assign rem_in  = '0;
            assign side_in = in_side;
        end else begin : g_tail
            assign n_in    = n_reg[i-1];
            assign r_in    = r_reg[i-1];
            assign rem_in  = rem_reg[i-1];
            assign side_in = side_reg[i-1];
        end

        assign rem_sh = {rem_in[RMW-3:0], n_in[NW-1 -: 2]};
        assign trial  = {r_in, 2'b01};
        assign ge     = rem_sh >= trial;

        always_ff @(posedge aclk) begin
            if (en) begin
                n_reg[i]    <= n_in << 2;
                r_reg[i]    <= {r_in[LW-2:0], ge};
                rem_reg[i]  <= ge ? (rem_sh - trial) : rem_sh;
                side_reg[i] <= side_in;
            end
        end
    end

    assign out_valid = vld_reg[NS-1];
    assign out_side  = side_reg[NS-1];
    assign out_root  = r_reg[NS-1];

endmodule

// ===== hdl/rcrd_div.sv =====
module rcrd_div #(
    parameter int FRAC_BITS = rcrd_pkg::FRAC_BITS_DEF
) (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     en,
    input  logic                     in_valid,
    input  rcrd_pkg::side_t          in_side,
    input  logic [rcrd_pkg::LW-1:0]  in_root,
    output logic                     out_valid,
    output rcrd_pkg::res_t           out_res
);

    localparam int AW  = rcrd_pkg::AW;
    localparam int LW  = rcrd_pkg::LW;
    localparam int DW  = rcrd_pkg::DW;
    localparam int QB  = FRAC_BITS + 1;
    localparam int NW  = AW + FRAC_BITS + 1;
    localparam int RDW = LW + 1;
    localparam int LIM = (FRAC_BITS >= 15) ? 32767 : (1 << FRAC_BITS);
    localparam int NL  = 2;

    logic [QB+1:0]     vld_reg;
    logic [LW-1:0]     l_reg   [QB+1];
    rcrd_pkg::flags_t  flg_reg [QB+1];
    logic [RDW-1:0]    rr_reg  [NL][QB+1];
    logic [QB-1:0]     lb_reg  [NL][QB+1];
    logic [QB-1:0]     q_reg   [NL][QB+1];
    logic [AW-1:0]     a_in    [NL];
    logic [NW-1:0]     n_next  [NL];
    logic              neg     [NL];
    logic signed [DW-1:0] ray_next [NL];
    rcrd_pkg::res_t    res_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (en) begin
            vld_reg <= {vld_reg[QB:0], in_valid};
        end
    end

    assign a_in[0] = in_side.ax;
    assign a_in[1] = in_side.ay;
    assign neg[0]  = flg_reg[QB].neg_x;
    assign neg[1]  = flg_reg[QB].neg_y;

    always_ff @(posedge aclk) begin
        if (en) begin
            l_reg[0]   <= in_root;
            flg_reg[0] <= in_side.flg;
        end
    end

    for (genvar j = 0; j < QB; j++) begin : g_side
        always_ff @(posedge aclk) begin
            if (en) begin
                l_reg[j+1]   <= l_reg[j];
                flg_reg[j+1] <= flg_reg[j];
            end
        end
    end

    for (genvar ln = 0; ln < NL; ln++) begin : g_lane
        logic [QB-1:0] q_sat;
        logic [DW-1:0] mag;

        // Dividend with half the divisor added rounds the quotient half up.
        assign n_next[ln] = (NW'(a_in[ln]) << FRAC_BITS) + NW'(in_root >> 1);

        // The quotient never exceeds 2^FRAC_BITS, so the upper dividend bits
        // are already below the divisor and start as the partial remainder.
        always_ff @(posedge aclk) begin
            if (en) begin
                rr_reg[ln][0] <= RDW'(n_next[ln] >> QB);
                lb_reg[ln][0] <= n_next[ln][QB-1:0];
                q_reg[ln][0]  <= '0;
            end
        end

        for (genvar j = 0; j < QB; j++) begin : g_step
            logic [RDW-1:0] t;
            logic           ge;

            assign t  = {rr_reg[ln][j][LW-1:0], lb_reg[ln][j][QB-1]};
            assign ge = t >= {1'b0, l_reg[j]};

            always_ff @(posedge aclk) begin
                if (en) begin
                    rr_reg[ln][j+1] <= ge ? (t - {1'b0, l_reg[j]}) : t;
                    lb_reg[ln][j+1] <= lb_reg[ln][j] << 1;
                    q_reg[ln][j+1]  <= {q_reg[ln][j][QB-2:0], ge};
                end
            end
        end

        assign q_sat = (q_reg[ln][QB] > QB'(LIM)) ? QB'(LIM) : q_reg[ln][QB];
        assign mag   = DW'(q_sat);

        always_comb begin
            if (flg_reg[QB].zero_len) begin
                ray_next[ln] = '0;
            end else if (neg[ln]) begin
                ray_next[ln] = -mag;
            end else begin
                ray_next[ln] = mag;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            res_reg.ray_x    <= ray_next[0];
            res_reg.ray_y    <= ray_next[1];
            res_reg.zero_len <= flg_reg[QB].zero_len;
        end
    end

    assign out_valid = vld_reg[QB+1];
    assign out_res   = res_reg;

endmodule

// ===== hdl/rcrd_out_buf.sv =====
module rcrd_out_buf (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           push,
    input  rcrd_pkg::res_t in_res,
    output logic           space,
    output logic           m_valid,
    input  logic           m_ready,
    output rcrd_pkg::res_t m_res
);

    logic [1:0]     count_reg;
    logic [1:0]     count_next;
    logic           wr_ptr_reg;
    logic           rd_ptr_reg;
    logic           pop;
    rcrd_pkg::res_t mem_reg [2];

    assign pop        = (count_reg != 2'd0) && m_ready;
    assign count_next = 2'(count_reg + 2'(push) - 2'(pop));

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg  <= 2'd0;
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
        end else begin
            count_reg <= count_next;
            if (push) begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (pop) begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= in_res;
        end
    end

    assign space   = count_reg != 2'd2;
    assign m_valid = count_reg != 2'd0;
    assign m_res   = mem_reg[rd_ptr_reg];

endmodule

// ===== hdl/rcrd_checker.sv =====
`include "raycast_column_ray_direction_defines.svh"

module rcrd_checker (
    input logic                                aclk,
    input logic                                aresetn,
    input logic                                s_ready,
    input logic                                m_valid,
    input logic                                m_ready,
    input logic signed [rcrd_pkg::DW-1:0]      m_ray_x,
    input logic signed [rcrd_pkg::DW-1:0]      m_ray_y,
    input logic                                m_zero_length
);

    `RCRD_ASSERT(a_zero_gives_zero, aclk, aresetn, m_valid && m_zero_length |-> m_ray_x == 16'sd0 && m_ray_y == 16'sd0, "zero-length result with nonzero ray")
    `RCRD_ASSERT(a_no_min_code, aclk, aresetn, m_valid |-> m_ray_x != 16'h8000 && m_ray_y != 16'h8000, "ray component outside the saturated range")
    `RCRD_ASSERT(a_hold_stalled, aclk, aresetn, m_valid && !m_ready |=> m_valid && $stable(m_ray_x) && $stable(m_ray_y) && $stable(m_zero_length), "stalled result changed")
    `RCRD_ASSERT_NR(a_reset_idle, aclk, !aresetn |=> !m_valid && !s_ready, "handshake active right after reset")

endmodule

bind raycast_column_ray_direction rcrd_checker u_rcrd_checker (
    .aclk          (aclk),
    .aresetn       (aresetn),
    .s_ready       (s_ready),
    .m_valid       (m_valid),
    .m_ready       (m_ready),
    .m_ray_x       (m_ray_x),
    .m_ray_y       (m_ray_y),
    .m_zero_length (m_zero_length)
);

// ===== dv/raycast_column_ray_direction_test.sv =====
`timescale 1ns / 1ps

// Self-checking bench for the column ray direction block.
//
// The bench keeps its own copy of the three view registers. Each time an input
// item is accepted, it computes the unit ray that the block must return for it.
// It queues that ray, and compares every result item against the oldest entry.
// Inputs change on the falling clock edge. Handshakes and results are sampled
// on the rising edge, so nothing depends on the order of events within a step.
module raycast_column_ray_direction_test;

    localparam int FRAC      = rcrd_pkg::FRAC_BITS_DEF;
    localparam int DW        = rcrd_pkg::DW;
    localparam int AW        = rcrd_pkg::AW;
    localparam int CFG_IDX_W = rcrd_pkg::CFG_IDX_W;
    // Pipeline depth of the block, from an accepted input to its valid result.
    localparam int LATENCY = FRAC + 44;
    // Weight of the forward term: one in the Q(2*FRAC+12) fraction of the ray sum.
    localparam longint FWD_UNIT = longint'(1) << (FRAC + 12);
    // Largest output magnitude: one, unless one does not fit in 16 bits.
    localparam longint unsigned MAG_LIMIT = (FRAC >= 15) ? 64'd32767 : (64'd1 << FRAC);
    // Cycles without any accepted input, result or register write before the run is declared hung.
    localparam int STALL_LIMIT = 5000;
    // Only the first mismatches are printed; all of them are counted.
    localparam int MAX_PRINTED = 100;

    logic                     aclk;
    logic                     aresetn;
    logic                     cfg_wr_en;
    logic [CFG_IDX_W-1:0]     cfg_index;
    logic [DW-1:0]            cfg_wdata;
    logic                     s_valid;
    logic                     s_ready;
    logic signed [DW-1:0]     s_screen_coord;
    logic                     m_valid;
    logic                     m_ready;
    logic signed [DW-1:0]     m_ray_x;
    logic signed [DW-1:0]     m_ray_y;
    logic                     m_zero_length;

    // Bench copy of the view registers, updated when they are written.
    logic signed [DW-1:0]     view_fwd_x;
    logic signed [DW-1:0]     view_fwd_y;
    logic [DW-1:0]            view_half_w;

    // Rays still owed by the block, oldest first.
    rcrd_pkg::res_t           pending_rays[$];
    rcrd_pkg::res_t           owed_ray;

    int                       mismatch_count;
    int                       stall_cycles;
    // Percent of cycles in which the sender or the receiver holds back.
    int                       send_idle_pct;
    int                       recv_idle_pct;

    raycast_column_ray_direction #(
        .FRAC_BITS(FRAC)
    ) uut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_index     (cfg_index),
        .cfg_wdata     (cfg_wdata),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_screen_coord(s_screen_coord),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_ray_x       (m_ray_x),
        .m_ray_y       (m_ray_y),
        .m_zero_length (m_zero_length)
    );

    always #5 aclk = ~aclk;

    // Integer square root, one result bit at a time from the top. The sum of
    // two squares stays below 2^61, so the root fits in 31 bits.
    function automatic longint unsigned floor_sqrt(longint unsigned radicand);
        longint unsigned root;
        longint unsigned trial;
        root = 0;
        for (int b = 31; b >= 0; b--) begin
            trial = root | (64'd1 << b);
            if (trial * trial <= radicand) begin
                root = trial;
            end
        end
        return root;
    endfunction

    // Divides one magnitude by the ray length, rounding half away from zero.
    // It then clamps the quotient to one and puts the sign back.
    function automatic logic [DW-1:0] unit_component(longint unsigned mag,
                                                     longint unsigned len, bit neg);
        longint unsigned q;
        q = ((mag << FRAC) + (len >> 1)) / len;
        if (q > MAG_LIMIT) begin
            q = MAG_LIMIT;
        end
        return neg ? DW'(-q) : DW'(q);
    endfunction

    // Unit ray for one screen coordinate under the current view registers.
    function automatic rcrd_pkg::res_t predict_ray(logic signed [DW-1:0] coord);
        longint          fx;
        longint          fy;
        longint          hc;
        longint          rx;
        longint          ry;
        longint unsigned mx;
        longint unsigned my;
        longint unsigned len;
        int              sh;
        rcrd_pkg::res_t  ray;
        fx = view_fwd_x;
        fy = view_fwd_y;
        hc = longint'(view_half_w) * longint'(coord);
        // Forward plus the offset along right = (fy, -fx), both held exactly.
        rx = fx * FWD_UNIT + hc * fy;
        ry = fy * FWD_UNIT - hc * fx;
        ray = '0;
        if (rx == 0 && ry == 0) begin
            ray.zero_len = 1'b1;
            return ray;
        end
        mx = (rx < 0) ? -rx : rx;
        my = (ry < 0) ? -ry : ry;
        // Truncate both magnitudes by the same shift until the larger one
        // fits in 30 bits. That keeps the sum of squares within 61 bits.
        sh = 0;
        while (((mx > my ? mx : my) >> sh) >= (64'd1 << AW)) begin
            sh++;
        end
        mx = mx >> sh;
        my = my >> sh;
        len = floor_sqrt(mx * mx + my * my);
        if (len == 0) begin
            ray.zero_len = 1'b1;
            return ray;
        end
        ray.ray_x = unit_component(mx, len, rx < 0);
        ray.ray_y = unit_component(my, len, ry < 0);
        return ray;
    endfunction

    task automatic report_mismatch(input string what, input int got, input int want);
        if (mismatch_count < MAX_PRINTED) begin
            $display("%0t: mismatch in %s: got %0d, expected %0d", $realtime, what, got, want);
        end
        mismatch_count++;
    endtask

    // Scoreboard. An accepted input queues its predicted ray. An accepted
    // result is checked field by field against the oldest queued ray.
    always @(posedge aclk) begin
        if (aresetn === 1'b1) begin
            if (s_valid && s_ready === 1'b1) begin
                pending_rays.push_back(predict_ray(s_screen_coord));
            end
            if (m_valid === 1'b1 && m_ready) begin
                if (pending_rays.size() == 0) begin
                    report_mismatch("result with nothing pending", m_ray_x, 0);
                end else begin
                    owed_ray = pending_rays.pop_front();
                    if (m_ray_x !== owed_ray.ray_x) begin
                        report_mismatch("ray_x", m_ray_x, owed_ray.ray_x);
                    end
                    if (m_ray_y !== owed_ray.ray_y) begin
                        report_mismatch("ray_y", m_ray_y, owed_ray.ray_y);
                    end
                    if (m_zero_length !== owed_ray.zero_len) begin
                        report_mismatch("zero_length", m_zero_length, owed_ray.zero_len);
                    end
                end
            end
        end
    end

    // Watchdog. Drains and the wait at the end stay far below the limit, so
    // running into it means the handshake has locked up.
    always @(posedge aclk) begin
        if ((s_valid && s_ready === 1'b1) || (m_valid === 1'b1 && m_ready) || cfg_wr_en) begin
            stall_cycles = 0;
        end else begin
            stall_cycles++;
        end
        if (stall_cycles >= STALL_LIMIT) begin
            $display("%0t: no item moved for %0d cycles", $realtime, STALL_LIMIT);
            $display("raycast_column_ray_direction_test NOT OK");
            $finish;
        end
    end

    // The receiver drops ready at random. With a zero percentage it always takes.
    always @(negedge aclk) begin
        m_ready = ($urandom_range(99) >= recv_idle_pct);
    end

    // Sends one coordinate. Before raising valid, the sender may sit idle with
    // noise on the payload. Once valid is up, it stays up with the same payload
    // until the item is accepted. The task returns right after that edge, so a
    // back-to-back item keeps valid high.
    task automatic send_coord(input logic [DW-1:0] coord);
        @(negedge aclk);
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid = 1'b0;
            s_screen_coord = DW'($urandom);
            @(negedge aclk);
        end
        s_valid = 1'b1;
        s_screen_coord = coord;
        @(posedge aclk);
        while (s_ready !== 1'b1) begin
            @(posedge aclk);
        end
    endtask

    // Lowers valid and waits until every owed ray has come back. Each item
    // gives exactly one ray, so an empty queue means an empty pipeline. The
    // extra wait at the end only makes the idle window obvious.
    task automatic drain_rays;
        @(negedge aclk);
        s_valid = 1'b0;
        while (pending_rays.size() != 0) begin
            @(negedge aclk);
        end
        repeat (4) @(negedge aclk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [DW-1:0] value);
        @(negedge aclk);
        cfg_wr_en = 1'b1;
        cfg_index = idx;
        cfg_wdata = value;
        case (idx)
            rcrd_pkg::REG_FORWARD_X: begin
                view_fwd_x = value;
            end
            rcrd_pkg::REG_FORWARD_Y: begin
                view_fwd_y = value;
            end
            rcrd_pkg::REG_HALF_WIDTH: begin
                view_half_w = value;
            end
            default: begin
            end
        endcase
        @(negedge aclk);
        cfg_wr_en = 1'b0;
    endtask

    // Waits for the block to go idle, then loads a full view.
    task automatic set_view(input logic [DW-1:0] fx, input logic [DW-1:0] fy,
                            input logic [DW-1:0] hw);
        drain_rays();
        write_reg(rcrd_pkg::REG_FORWARD_X, fx);
        write_reg(rcrd_pkg::REG_FORWARD_Y, fy);
        write_reg(rcrd_pkg::REG_HALF_WIDTH, hw);
    endtask

    // Straight after reset the view looks along +y with zero width. Every
    // column must therefore give the forward ray.
    task automatic test_reset_view;
        send_coord(-16'sd16384);
        send_coord(16'sd0);
        send_coord(16'sd16384);
    endtask

    // Forward along +x with a 90 degree field of view. The screen edges give
    // the two diagonals, and the center gives forward itself.
    task automatic test_right_angle_fov;
        set_view(16'sd16384, 16'sd0, 16'd4096);
        send_coord(-16'sd16384);
        send_coord(16'sd16384);
        send_coord(16'sd0);
        send_coord(16'sd8192);
    endtask

    // A zero forward vector collapses every ray to zero length.
    task automatic test_zero_forward;
        set_view(16'sd0, 16'sd0, 16'hFFFF);
        send_coord(16'sd16384);
        send_coord(-16'sd32768);
    endtask

    // All registers sit at their 16-bit limits; the coordinates include both limits.
    task automatic test_extreme_fields;
        set_view(-16'sd32768, 16'sd32767, 16'hFFFF);
        send_coord(-16'sd32768);
        send_coord(16'sd32767);
        send_coord(-16'sd1);
        send_coord(16'sd1);
        send_coord(16'sd16384);
        send_coord(-16'sd16384);
    endtask

    // A forward vector far from unit length must still come out normalized.
    task automatic test_tiny_forward;
        set_view(16'sd1, -16'sd1, 16'd1);
        send_coord(16'sd0);
        send_coord(16'sd32767);
        send_coord(-16'sd32768);
    endtask

    // Checks the rounding around magnitude one. A diagonal gives 1/sqrt(2).
    // A pure axis ray lands exactly on the clamp.
    task automatic test_unit_rounding;
        set_view(16'sd16384, 16'sd16384, 16'd0);
        send_coord(16'sd0);
        set_view(16'sd32767, 16'sd0, 16'd0);
        send_coord(16'sd0);
    endtask

    // Mostly forward vectors inside the unit range and moderate widths. Some
    // views use arbitrary bit patterns, and a few have a zero forward vector.
    task automatic load_random_view;
        int pick;
        pick = $urandom_range(9);
        if (pick == 0) begin
            set_view(DW'($urandom), DW'($urandom),
                     ($urandom_range(1) != 0) ? 16'hFFFF : DW'($urandom));
        end else if (pick == 1) begin
            set_view(16'sd0, 16'sd0, DW'($urandom));
        end else if (pick == 2) begin
            set_view(DW'($urandom_range(32768) - 16384), DW'($urandom_range(32768) - 16384),
                     16'd0);
        end else begin
            set_view(DW'($urandom_range(32768) - 16384), DW'($urandom_range(32768) - 16384),
                     DW'($urandom_range(8192)));
        end
    endtask

    // Coordinates: mostly inside [-1, 1], some arbitrary bit patterns, and a
    // few at the screen edges and the center.
    function automatic logic [DW-1:0] random_coord;
        int pick;
        pick = $urandom_range(99);
        if (pick < 85) begin
            return DW'($urandom_range(32768) - 16384);
        end else if (pick < 95) begin
            return DW'($urandom);
        end else begin
            case ($urandom_range(2))
                0: return -16'sd16384;
                1: return 16'sd16384;
                default: return 16'sd0;
            endcase
        end
    endfunction

    // One random phase. The item count is split over several views. Each
    // view change makes the sender wait until every owed ray has arrived.
    task automatic run_random_phase(input int send_pct, input int recv_pct, input int count);
        int per_view;
        send_idle_pct = send_pct;
        recv_idle_pct = recv_pct;
        per_view = count / 5;
        for (int v = 0; v < 5; v++) begin
            load_random_view();
            for (int i = 0; i < per_view; i++) begin
                send_coord(random_coord());
            end
        end
    endtask

    task automatic test_random_sender_idle;
        run_random_phase(14, 58, 650);
    endtask

    task automatic test_random_receiver_idle;
        run_random_phase(58, 14, 650);
    endtask

    task automatic test_random_full_rate;
        run_random_phase(0, 0, 650);
    endtask

    initial begin
        aclk = 1'b0;
        aresetn = 1'b0;
        cfg_wr_en = 1'b0;
        cfg_index = rcrd_pkg::REG_FORWARD_X;
        cfg_wdata = '0;
        s_valid = 1'b0;
        s_screen_coord = '0;
        m_ready = 1'b0;
        mismatch_count = 0;
        stall_cycles = 0;
        send_idle_pct = 0;
        recv_idle_pct = 0;
        // Register values after reset.
        view_fwd_x = '0;
        view_fwd_y = rcrd_pkg::FORWARD_Y_RST;
        view_half_w = '0;

        repeat (8) @(negedge aclk);
        aresetn = 1'b1;

        test_reset_view();
        test_right_angle_fov();
        test_zero_forward();
        test_extreme_fields();
        test_tiny_forward();
        test_unit_rounding();
        test_random_sender_idle();
        test_random_receiver_idle();
        test_random_full_rate();

        // Every ray is back. Keep the clock running past the pipeline depth so that a
        // stray extra result would still show up as a mismatch.
        drain_rays();
        repeat (LATENCY + 8) @(posedge aclk);

        if (mismatch_count == 0) begin
            $display("raycast_column_ray_direction_test OK");
        end else begin
            $display("raycast_column_ray_direction_test NOT OK");
        end
        $finish;
    end

endmodule
